[hw/rtl/ccfr_pkg.sv]
package ccfr_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } ccfr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_error;
    logic [2:0] error_code;
    logic       last;
    logic [4:0] payload_length;
  } ccfr_out_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN_RD,
    ST_DRAIN_WR
  } state_t;

  localparam logic       ACT_BYTE = 1'b0;
  localparam logic       ACT_TICK = 1'b1;

  localparam logic [2:0] ERR_BAD_HEADER = 3'd0;
  localparam logic [2:0] ERR_ZERO_LEN   = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd2;
  localparam logic [2:0] ERR_CRC        = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT    = 3'd4;

  localparam logic [7:0]  HDR_FIRST    = 8'h4D;  // 'M'
  localparam logic [7:0]  HDR_SECOND   = 8'h4C;  // 'L'
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  TIMEOUT_RST  = 8'd2;

  // CRC-16/MODBUS, one byte, LSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/crc_checked_frame_receiver.sv]
// Channel  Dir  Handshake              Payload
// in_      in   in_valid / in_ready    ccfr_in_t  (byte or tick)
// out_     out  out_valid / out_ready  ccfr_out_t (payload byte or error)
// cfg_     in   cfg_wr_en              frame timeout in ticks
//
// Byte or tick transactions are accepted only while the block is receiving.
// A good frame drains its payload from the buffer RAM one byte at a time
// (registered read, then output load); input is held off during the drain.
// Reset is synchronous; the buffer is not cleared, only written entries are read.
// A stalled output register holds off input until its transaction goes out.
module crc_checked_frame_receiver #(
  parameter int MAX_PDU = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ccfr_pkg::ccfr_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ccfr_pkg::ccfr_out_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data
);
  import ccfr_pkg::*;

  localparam int LEN_W = $clog2(MAX_PDU + 1);
  localparam int AW    = (MAX_PDU > 1) ? $clog2(MAX_PDU) : 1;

  logic [7:0] mem [MAX_PDU];
  logic [7:0] mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  hdr_first_r, hdr_first_nxt;
  logic [7:0]  hdr_second_r, hdr_second_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  chk_first_r, chk_first_nxt;
  logic        chk_cnt_r, chk_cnt_nxt;
  logic [7:0]  gap_r, gap_nxt;
  logic [7:0]  timeout_r;
  logic        out_valid_r, out_valid_nxt;
  ccfr_out_t   out_data_r, out_data_nxt;

  logic        in_fire;
  logic        slot_free;
  logic [15:0] crc_b;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_RUN) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign crc_b     = crc16_step(crc_r, in_data.in_byte);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic       err;
    logic [2:0] err_code;
    logic [7:0] gap_inc;
    logic       last;
    err      = 1'b0;
    err_code = ERR_BAD_HEADER;
    gap_inc  = gap_r + 8'd1;
    last     = (LEN_W'(k_r + 1'b1) == len_r);

    state_nxt      = state_r;
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    hdr_first_nxt  = hdr_first_r;
    hdr_second_nxt = hdr_second_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    crc_nxt        = crc_r;
    chk_first_nxt  = chk_first_r;
    chk_cnt_nxt    = chk_cnt_r;
    gap_nxt        = gap_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wa         = cnt_r[AW-1:0];
    mem_wd         = in_data.in_byte;

    unique case (state_r)
      ST_RUN: begin
        if (in_fire) begin
          if (in_data.action == ACT_TICK) begin
            if (phase_r != PH_HEADER) begin
              gap_nxt = gap_inc;
              if (gap_inc >= timeout_r) begin
                err      = 1'b1;
                err_code = ERR_TIMEOUT;
              end
            end
          end else begin
            unique case (phase_r)
              PH_HEADER: begin
                crc_nxt = crc_b;
                unique case (hdr_cnt_r)
                  2'd0: begin
                    hdr_first_nxt = in_data.in_byte;
                    hdr_cnt_nxt   = 2'd1;
                  end
                  2'd1: begin
                    hdr_second_nxt = in_data.in_byte;
                    hdr_cnt_nxt    = 2'd2;
                  end
                  default: begin
                    priority if (hdr_first_r != HDR_FIRST || hdr_second_r != HDR_SECOND) begin
                      err      = 1'b1;
                      err_code = ERR_BAD_HEADER;
                    end else if (in_data.in_byte == 8'd0) begin
                      err      = 1'b1;
                      err_code = ERR_ZERO_LEN;
                    end else if (in_data.in_byte > 8'(MAX_PDU)) begin
                      err      = 1'b1;
                      err_code = ERR_TOO_LONG;
                    end else begin
                      len_nxt   = in_data.in_byte[LEN_W-1:0];
                      cnt_nxt   = '0;
                      gap_nxt   = 8'd0;
                      phase_nxt = PH_PAYLOAD;
                    end
                  end
                endcase
              end
              PH_PAYLOAD: begin
                gap_nxt = 8'd0;
                mem_we  = (cnt_r < len_r);
                cnt_nxt = LEN_W'(cnt_r + 1'b1);
                crc_nxt = crc_b;
                if (cnt_nxt == len_r) begin
                  phase_nxt   = PH_CHECK;
                  chk_cnt_nxt = 1'b0;
                end
              end
              default: begin
                gap_nxt = 8'd0;
                if (!chk_cnt_r) begin
                  chk_first_nxt = in_data.in_byte;
                  chk_cnt_nxt   = 1'b1;
                end else if ({chk_first_r, in_data.in_byte} != crc_r) begin
                  err      = 1'b1;
                  err_code = ERR_CRC;
                end else begin
                  // good frame: back to hunting, keep length for the drain
                  state_nxt      = ST_DRAIN_RD;
                  k_nxt          = '0;
                  phase_nxt      = PH_HEADER;
                  hdr_cnt_nxt    = 2'd0;
                  hdr_first_nxt  = 8'd0;
                  hdr_second_nxt = 8'd0;
                  cnt_nxt        = '0;
                  crc_nxt        = CRC_INIT;
                  chk_first_nxt  = 8'd0;
                  chk_cnt_nxt    = 1'b0;
                  gap_nxt        = 8'd0;
                end
              end
            endcase
          end
        end
      end
      ST_DRAIN_RD: begin
        state_nxt = ST_DRAIN_WR;
      end
      default: begin
        if (slot_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.out_byte       = mem_q;
          out_data_nxt.is_error       = 1'b0;
          out_data_nxt.error_code     = ERR_BAD_HEADER;
          out_data_nxt.last           = last;
          out_data_nxt.payload_length = 5'(len_r);
          if (last) begin
            state_nxt = ST_RUN;
          end else begin
            k_nxt     = LEN_W'(k_r + 1'b1);
            state_nxt = ST_DRAIN_RD;
          end
        end
      end
    endcase

    if (err) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.out_byte       = 8'd0;
      out_data_nxt.is_error       = 1'b1;
      out_data_nxt.error_code     = err_code;
      out_data_nxt.last           = 1'b1;
      out_data_nxt.payload_length = 5'd0;
      phase_nxt      = PH_HEADER;
      hdr_cnt_nxt    = 2'd0;
      hdr_first_nxt  = 8'd0;
      hdr_second_nxt = 8'd0;
      len_nxt        = '0;
      cnt_nxt        = '0;
      crc_nxt        = CRC_INIT;
      chk_first_nxt  = 8'd0;
      chk_cnt_nxt    = 1'b0;
      gap_nxt        = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      phase_r      <= PH_HEADER;
      hdr_cnt_r    <= 2'd0;
      hdr_first_r  <= 8'd0;
      hdr_second_r <= 8'd0;
      len_r        <= '0;
      cnt_r        <= '0;
      k_r          <= '0;
      crc_r        <= CRC_INIT;
      chk_first_r  <= 8'd0;
      chk_cnt_r    <= 1'b0;
      gap_r        <= 8'd0;
      timeout_r    <= TIMEOUT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      hdr_first_r  <= hdr_first_nxt;
      hdr_second_r <= hdr_second_nxt;
      len_r        <= len_nxt;
      cnt_r        <= cnt_nxt;
      k_r          <= k_nxt;
      crc_r        <= crc_nxt;
      chk_first_r  <= chk_first_nxt;
      chk_cnt_r    <= chk_cnt_nxt;
      gap_r        <= gap_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // payload buffer, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[k_r[AW-1:0]];
  end

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.is_error |-> out_data_r.last && out_data_r.payload_length == 5'd0)
    else $error("error transaction without last or with a length");

  a_drain_hunting: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_RUN |-> phase_r == PH_HEADER && !in_ready)
    else $error("drain overlaps frame reception");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> cnt_r < len_r)
    else $error("payload count past frame length");

  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN_WR && slot_free && (LEN_W'(k_r + 1'b1) == len_r)
    |=> state_r == ST_RUN && out_valid_r && out_data_r.last)
    else $error("drain did not end on the last payload byte");

endmodule
